[hw/rtl/dcpt_pkg.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// dcpt_pkg: shared types and constants for the dual-chamber pacing timer
// Holds pace codes, timer slot numbers, configuration register indexes and
// the request and result structures that pass between the timer modules.
// ---------------------------------------------------------------------------
package dcpt_pkg;

    localparam int unsigned CNT_W      = 16;
    localparam int unsigned CODE_W     = 2;
    localparam int unsigned NUM_TIMERS = 6;
    localparam int unsigned CFG_IDX_W  = 3;

    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

    // Pace status codes.
    localparam logic [CODE_W-1:0] CODE_IDLE      = 2'd0;
    localparam logic [CODE_W-1:0] CODE_REQUESTED = 2'd1;
    localparam logic [CODE_W-1:0] CODE_DELIVERED = 2'd2;

    // Timer slots, which are also the bit positions in the phase word.
    localparam int unsigned T_AVI   = 0;
    localparam int unsigned T_PVARP = 1;
    localparam int unsigned T_VRP   = 2;
    localparam int unsigned T_AEI   = 3;
    localparam int unsigned T_LRI   = 4;
    localparam int unsigned T_URI   = 5;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_AV_DELAY    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PVARP       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_VRP         = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ATRIAL_ESC  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_LOWER_RATE  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_UPPER_RATE  = 3'd5;

    // Reset values of the limits.
    localparam logic [CNT_W-1:0] RST_AV_DELAY   = 16'd300;
    localparam logic [CNT_W-1:0] RST_PVARP      = 16'd50;
    localparam logic [CNT_W-1:0] RST_VRP        = 16'd150;
    localparam logic [CNT_W-1:0] RST_ATRIAL_ESC = 16'd800;
    localparam logic [CNT_W-1:0] RST_LOWER_RATE = 16'd950;
    localparam logic [CNT_W-1:0] RST_UPPER_RATE = 16'd900;

    typedef logic [CNT_W-1:0] count_t;
    typedef logic [CODE_W-1:0] code_t;
    typedef logic [NUM_TIMERS-1:0] phases_t;

    // Interval limits, one per timer.
    typedef struct packed {
        count_t av_delay;
        count_t pvarp;
        count_t vrp;
        count_t atrial_escape;
        count_t lower_rate;
        count_t upper_rate;
    } limits_t;

    // One tick request.
    typedef struct packed {
        logic  atrial_sense;
        logic  ventricular_sense;
        code_t atrial_code;
        code_t ventricular_code;
    } tick_t;

    // One tick result.
    typedef struct packed {
        code_t   atrial_code;
        code_t   ventricular_code;
        phases_t phases;
    } result_t;

    // Saturating counter increment.
    function automatic count_t inc_sat(input count_t c);
        return (c == CNT_MAX) ? CNT_MAX : count_t'(c + 1'b1);
    endfunction

endpackage : dcpt_pkg
`default_nettype wire

[hw/rtl/dual_chamber_pacing_timer_unit.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// dual_chamber_pacing_timer_unit: dual-chamber pacing interval timer
// Top level with the request register, the timer bank and the result
// register.
// ---------------------------------------------------------------------------
// The unit takes one tick request per clock cycle while no result stalls,
// and returns one result per tick. A request is captured in an input
// register, the six timer rules are evaluated in one pass, and the result
// is held in an output register until it is taken. The throughput of one
// tick per cycle, when no result stalls, rests on the rule pass between
// those two registers; a stalled result holds back at most one further
// request. Limits are to be written through the configuration port only
// while no tick is in flight; the block itself does not enforce this.
// The limits reset to 300, 50, 150, 800, 950 and 900 ticks.
module dual_chamber_pacing_timer_unit (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    // Configuration port
    input  wire logic                           cfg_wr_en,
    input  wire logic [dcpt_pkg::CFG_IDX_W-1:0] cfg_wr_index,
    input  wire logic [dcpt_pkg::CNT_W-1:0]     cfg_wr_data,
    // Tick request channel
    input  wire logic                           s_valid,
    output logic                                s_ready,
    input  wire logic                           s_atrial_sense,
    input  wire logic                           s_ventricular_sense,
    input  wire logic [dcpt_pkg::CODE_W-1:0]    s_atrial_pace_code,
    input  wire logic [dcpt_pkg::CODE_W-1:0]    s_ventricular_pace_code,
    // Result channel
    output logic                                m_valid,
    input  wire logic                           m_ready,
    output logic [dcpt_pkg::CODE_W-1:0]         m_atrial_pace_code_out,
    output logic [dcpt_pkg::CODE_W-1:0]         m_ventricular_pace_code_out,
    output logic [dcpt_pkg::NUM_TIMERS-1:0]     m_timer_phases
);
    import dcpt_pkg::*;

    limits_t limits;
    tick_t   tick_reg;
    logic    in_vld_reg;
    logic    in_vld_next;
    result_t tick_result;
    result_t res_reg;
    logic    out_vld_reg;
    logic    out_vld_next;
    logic    s_fire;
    logic    tick_fire;

    // Limit registers.
    dcpt_cfg_regs u_cfg_regs (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_en    (cfg_wr_en),
        .wr_index (cfg_wr_index),
        .wr_data  (cfg_wr_data),
        .limits   (limits)
    );

    // Handshake: the held request moves on whenever the result slot is free
    // or being emptied in this cycle.
    assign tick_fire    = in_vld_reg && (!out_vld_reg || m_ready);
    assign s_ready      = !in_vld_reg || tick_fire;
    assign s_fire       = s_valid && s_ready;
    assign in_vld_next  = s_fire || (in_vld_reg && !tick_fire);
    assign out_vld_next = tick_fire || (out_vld_reg && !m_ready);

    // Request register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else begin
            in_vld_reg <= in_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            tick_reg.atrial_sense      <= s_atrial_sense;
            tick_reg.ventricular_sense <= s_ventricular_sense;
            tick_reg.atrial_code       <= s_atrial_pace_code;
            tick_reg.ventricular_code  <= s_ventricular_pace_code;
        end
    end

    // Timer rules and state.
    dcpt_timer_bank u_timer_bank (
        .aclk    (aclk),
        .aresetn (aresetn),
        .tick_en (tick_fire),
        .tick    (tick_reg),
        .limits  (limits),
        .result  (tick_result)
    );

    // Result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else begin
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (tick_fire) begin
            res_reg <= tick_result;
        end
    end

    assign m_valid                     = out_vld_reg;
    assign m_atrial_pace_code_out      = res_reg.atrial_code;
    assign m_ventricular_pace_code_out = res_reg.ventricular_code;
    assign m_timer_phases              = res_reg.phases;

endmodule : dual_chamber_pacing_timer_unit
`default_nettype wire

[hw/rtl/dcpt_cfg_regs.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// dcpt_cfg_regs: interval limit registers
// Six 16-bit limits written through a plain write port. Writes to an index
// beyond the last register are dropped.
// ---------------------------------------------------------------------------
module dcpt_cfg_regs (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           wr_en,
    input  wire logic [dcpt_pkg::CFG_IDX_W-1:0] wr_index,
    input  wire logic [dcpt_pkg::CNT_W-1:0]     wr_data,
    output dcpt_pkg::limits_t                   limits
);
    import dcpt_pkg::*;

    limits_t limits_reg;
    limits_t limits_next;

    // Decode the register index.
    always_comb begin
        limits_next = limits_reg;
        if (wr_en) begin
            unique case (wr_index)
                REG_AV_DELAY:   limits_next.av_delay      = wr_data;
                REG_PVARP:      limits_next.pvarp         = wr_data;
                REG_VRP:        limits_next.vrp           = wr_data;
                REG_ATRIAL_ESC: limits_next.atrial_escape = wr_data;
                REG_LOWER_RATE: limits_next.lower_rate    = wr_data;
                REG_UPPER_RATE: limits_next.upper_rate    = wr_data;
                default:        limits_next = limits_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limits_reg.av_delay      <= RST_AV_DELAY;
            limits_reg.pvarp         <= RST_PVARP;
            limits_reg.vrp           <= RST_VRP;
            limits_reg.atrial_escape <= RST_ATRIAL_ESC;
            limits_reg.lower_rate    <= RST_LOWER_RATE;
            limits_reg.upper_rate    <= RST_UPPER_RATE;
        end else begin
            limits_reg <= limits_next;
        end
    end

    assign limits = limits_reg;

endmodule : dcpt_cfg_regs
`default_nettype wire

[hw/rtl/dcpt_timer_bank.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// dcpt_timer_bank: six interval timers and the per-tick rule logic
// Holds the running bits and counters of AVI, PVARP, VRP, AEI, LRI and URI,
// evaluates the rules of one tick in order, and commits the new state when
// the tick is taken.
// ---------------------------------------------------------------------------
module dcpt_timer_bank (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              tick_en,
    input  wire dcpt_pkg::tick_t   tick,
    input  wire dcpt_pkg::limits_t limits,
    output dcpt_pkg::result_t      result
);
    import dcpt_pkg::*;

    phases_t run_reg;
    phases_t run_next;
    count_t  count_reg  [NUM_TIMERS];
    count_t  count_next [NUM_TIMERS];
    code_t   ap_final;
    code_t   vp_final;

    // Rule evaluation. Every rule reads the running bits from the start of
    // the tick; pace requests raised by earlier rules are seen by later ones.
    always_comb begin : rules_comb
        logic  a_evt;
        logic  v_evt;
        code_t ap;
        code_t vp;

        run_next   = run_reg;
        count_next = count_reg;
        ap = tick.atrial_code;
        vp = tick.ventricular_code;
        a_evt = tick.atrial_sense || (ap == CODE_DELIVERED);

        // AV interval.
        if (!run_reg[T_AVI]) begin
            if (a_evt && !run_reg[T_PVARP]) begin
                run_next[T_AVI]   = 1'b1;
                count_next[T_AVI] = '0;
            end
        end else begin
            if ((count_reg[T_AVI] >= limits.av_delay) && !run_reg[T_URI]) begin
                vp = CODE_REQUESTED;
                run_next[T_AVI] = 1'b0;
            end
            if (tick.ventricular_sense) begin
                run_next[T_AVI] = 1'b0;
            end
            count_next[T_AVI] = inc_sat(count_reg[T_AVI]);
        end

        v_evt = tick.ventricular_sense || (vp == CODE_DELIVERED);

        // Post-ventricular atrial refractory period.
        if (!run_reg[T_PVARP]) begin
            if (v_evt) begin
                run_next[T_PVARP]   = 1'b1;
                count_next[T_PVARP] = '0;
            end
        end else begin
            if (count_reg[T_PVARP] >= limits.pvarp) begin
                run_next[T_PVARP] = 1'b0;
            end
            count_next[T_PVARP] = inc_sat(count_reg[T_PVARP]);
        end

        // Ventricular refractory period.
        if (!run_reg[T_VRP]) begin
            if (v_evt) begin
                run_next[T_VRP]   = 1'b1;
                count_next[T_VRP] = '0;
            end
        end else begin
            if (count_reg[T_VRP] >= limits.vrp) begin
                run_next[T_VRP] = 1'b0;
            end
            count_next[T_VRP] = inc_sat(count_reg[T_VRP]);
        end

        // Atrial escape interval.
        if (!run_reg[T_AEI]) begin
            if (v_evt && !run_reg[T_VRP]) begin
                run_next[T_AEI]   = 1'b1;
                count_next[T_AEI] = '0;
            end
        end else begin
            if (count_reg[T_AEI] >= limits.atrial_escape) begin
                ap = CODE_REQUESTED;
                run_next[T_AEI] = 1'b0;
            end
            if (tick.atrial_sense && !run_reg[T_PVARP]) begin
                run_next[T_AEI] = 1'b0;
            end
            count_next[T_AEI] = inc_sat(count_reg[T_AEI]);
        end

        // Lower rate interval; once started it keeps running.
        if (!run_reg[T_LRI]) begin
            if (v_evt && !run_reg[T_VRP]) begin
                run_next[T_LRI]   = 1'b1;
                count_next[T_LRI] = '0;
            end
        end else begin
            count_next[T_LRI] = count_reg[T_LRI];
            if (count_reg[T_LRI] >= limits.lower_rate) begin
                vp = CODE_REQUESTED;
                count_next[T_LRI] = '0;
            end
            if ((tick.ventricular_sense || (vp == CODE_DELIVERED)) && !run_reg[T_VRP]) begin
                count_next[T_LRI] = '0;
            end
            count_next[T_LRI] = inc_sat(count_next[T_LRI]);
        end

        // Upper rate interval sees the ventricular code after the LRI rule.
        if (!run_reg[T_URI]) begin
            if ((tick.ventricular_sense || (vp == CODE_DELIVERED)) && !run_reg[T_VRP]) begin
                run_next[T_URI]   = 1'b1;
                count_next[T_URI] = '0;
            end
        end else begin
            if (count_reg[T_URI] >= limits.upper_rate) begin
                run_next[T_URI] = 1'b0;
            end
            count_next[T_URI] = inc_sat(count_reg[T_URI]);
        end

        // Delivered codes return to idle at the end of the tick.
        ap_final = (ap == CODE_DELIVERED) ? CODE_IDLE : ap;
        vp_final = (vp == CODE_DELIVERED) ? CODE_IDLE : vp;
    end

    // Timer state commits only when a tick is taken.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg <= '0;
            for (int i = 0; i < NUM_TIMERS; i++) begin
                count_reg[i] <= '0;
            end
        end else if (tick_en) begin
            run_reg   <= run_next;
            count_reg <= count_next;
        end
    end

    assign result.atrial_code      = ap_final;
    assign result.ventricular_code = vp_final;
    assign result.phases           = run_next;

endmodule : dcpt_timer_bank
`default_nettype wire

[hw/rtl/dcpt_checker.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// dcpt_checker: port-level checks for the pacing timer unit
// Watches the top-level ports and flags result handshake slips, a result
// valid out of reset, delivered codes leaking out, and a stopped LRI timer.
// ---------------------------------------------------------------------------
module dcpt_checker (
    input wire logic                            aclk,
    input wire logic                            aresetn,
    input wire logic                            m_valid,
    input wire logic                            m_ready,
    input wire logic [dcpt_pkg::CODE_W-1:0]     m_atrial_pace_code_out,
    input wire logic [dcpt_pkg::CODE_W-1:0]     m_ventricular_pace_code_out,
    input wire logic [dcpt_pkg::NUM_TIMERS-1:0] m_timer_phases
);
    import dcpt_pkg::*;

    // A stalled result keeps its valid and its payload.
    a_result_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid
            && $stable(m_atrial_pace_code_out)
            && $stable(m_ventricular_pace_code_out)
            && $stable(m_timer_phases)))
        else $error("result changed while stalled");

    // No result is shown in the first cycle out of reset.
    a_reset_empty: assert property (@(posedge aclk)
        (aresetn && $past(!aresetn)) |-> !m_valid)
        else $error("result valid right after reset");

    // Delivered codes are always cleared before they leave.
    a_atrial_not_delivered: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_atrial_pace_code_out != CODE_DELIVERED))
        else $error("atrial delivered code in result");

    a_vent_not_delivered: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_ventricular_pace_code_out != CODE_DELIVERED))
        else $error("ventricular delivered code in result");

    // The lower rate timer never stops once it has started.
    a_lri_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        ((m_valid && m_ready && m_timer_phases[T_LRI]) ##1 m_valid)
            |-> m_timer_phases[T_LRI])
        else $error("lower rate timer stopped");

endmodule : dcpt_checker

bind dual_chamber_pacing_timer_unit dcpt_checker u_dcpt_checker (.*);
`default_nettype wire

[test/tb_dual_chamber_pacing_timer_unit.sv]
// ---------------------------------------------------------------------------
// tb_dual_chamber_pacing_timer_unit: self-checking bench for the pacing timer
// Drives tick requests with random gaps and result back-pressure, predicts
// each result with a cycle-free model of the six interval timers, and
// checks every result field in order. Limits are reprogrammed between runs.
// ---------------------------------------------------------------------------
import dcpt_pkg::*;

// Scoreboard: mirrors the timer bank and holds the results still to come.
class pacing_scoreboard;
    limits_t     lim;
    phases_t     running;
    count_t      counts [NUM_TIMERS];
    result_t     expected_results [$];
    code_t       last_atrial;
    code_t       last_ventricular;
    int unsigned errors;

    function new();
        lim.av_delay      = RST_AV_DELAY;
        lim.pvarp         = RST_PVARP;
        lim.vrp           = RST_VRP;
        lim.atrial_escape = RST_ATRIAL_ESC;
        lim.lower_rate    = RST_LOWER_RATE;
        lim.upper_rate    = RST_UPPER_RATE;
        running           = '0;
        foreach (counts[i]) counts[i] = '0;
        last_atrial       = CODE_IDLE;
        last_ventricular  = CODE_IDLE;
        errors            = 0;
    endfunction

    // Indexes outside the register map are dropped by the block.
    function void write_limit(logic [CFG_IDX_W-1:0] idx, count_t value);
        case (idx)
            REG_AV_DELAY:   lim.av_delay      = value;
            REG_PVARP:      lim.pvarp         = value;
            REG_VRP:        lim.vrp           = value;
            REG_ATRIAL_ESC: lim.atrial_escape = value;
            REG_LOWER_RATE: lim.lower_rate    = value;
            REG_UPPER_RATE: lim.upper_rate    = value;
            default: ;
        endcase
    endfunction

    // Counters stick at the top instead of wrapping.
    function count_t bump(count_t c);
        return (c == CNT_MAX) ? c : count_t'(c + 1'b1);
    endfunction

    function int unsigned pending();
        return expected_results.size();
    endfunction

    // Work out the result of one accepted tick and queue it.
    function void note_tick(tick_t t);
        phases_t old_run;
        phases_t new_run;
        code_t   a_code;
        code_t   v_code;
        logic    a_sense;
        logic    v_sense;
        result_t res;

        old_run = running;
        new_run = running;
        a_sense = t.atrial_sense;
        v_sense = t.ventricular_sense;
        a_code  = t.atrial_code;
        v_code  = t.ventricular_code;

        // AV delay: started by an atrial event outside the atrial refractory.
        if (!old_run[T_AVI]) begin
            if ((a_sense || a_code == CODE_DELIVERED) && !old_run[T_PVARP]) begin
                new_run[T_AVI] = 1'b1;
                counts[T_AVI]  = '0;
            end
        end else begin
            if (counts[T_AVI] >= lim.av_delay && !old_run[T_URI]) begin
                v_code         = CODE_REQUESTED;
                new_run[T_AVI] = 1'b0;
            end
            if (v_sense) new_run[T_AVI] = 1'b0;
            counts[T_AVI] = bump(counts[T_AVI]);
        end

        // Post-ventricular atrial refractory period.
        if (!old_run[T_PVARP]) begin
            if (v_sense || v_code == CODE_DELIVERED) begin
                new_run[T_PVARP] = 1'b1;
                counts[T_PVARP]  = '0;
            end
        end else begin
            if (counts[T_PVARP] >= lim.pvarp) new_run[T_PVARP] = 1'b0;
            counts[T_PVARP] = bump(counts[T_PVARP]);
        end

        // Ventricular refractory period.
        if (!old_run[T_VRP]) begin
            if (v_sense || v_code == CODE_DELIVERED) begin
                new_run[T_VRP] = 1'b1;
                counts[T_VRP]  = '0;
            end
        end else begin
            if (counts[T_VRP] >= lim.vrp) new_run[T_VRP] = 1'b0;
            counts[T_VRP] = bump(counts[T_VRP]);
        end

        // Atrial escape: paces the atrium unless inhibited by an atrial sense.
        if (!old_run[T_AEI]) begin
            if ((v_sense || v_code == CODE_DELIVERED) && !old_run[T_VRP]) begin
                new_run[T_AEI] = 1'b1;
                counts[T_AEI]  = '0;
            end
        end else begin
            if (counts[T_AEI] >= lim.atrial_escape) begin
                a_code         = CODE_REQUESTED;
                new_run[T_AEI] = 1'b0;
            end
            if (a_sense && !old_run[T_PVARP]) new_run[T_AEI] = 1'b0;
            counts[T_AEI] = bump(counts[T_AEI]);
        end

        // Lower rate: free-running once started, restarted by V events.
        if (!old_run[T_LRI]) begin
            if ((v_sense || v_code == CODE_DELIVERED) && !old_run[T_VRP]) begin
                new_run[T_LRI] = 1'b1;
                counts[T_LRI]  = '0;
            end
        end else begin
            if (counts[T_LRI] >= lim.lower_rate) begin
                v_code        = CODE_REQUESTED;
                counts[T_LRI] = '0;
            end
            if ((v_sense || v_code == CODE_DELIVERED) && !old_run[T_VRP])
                counts[T_LRI] = '0;
            counts[T_LRI] = bump(counts[T_LRI]);
        end

        // Upper rate: blocks the AV pace while it runs.
        if (!old_run[T_URI]) begin
            if ((v_sense || v_code == CODE_DELIVERED) && !old_run[T_VRP]) begin
                new_run[T_URI] = 1'b1;
                counts[T_URI]  = '0;
            end
        end else begin
            if (counts[T_URI] >= lim.upper_rate) new_run[T_URI] = 1'b0;
            counts[T_URI] = bump(counts[T_URI]);
        end

        running = new_run;
        if (a_code == CODE_DELIVERED) a_code = CODE_IDLE;
        if (v_code == CODE_DELIVERED) v_code = CODE_IDLE;

        res.atrial_code      = a_code;
        res.ventricular_code = v_code;
        res.phases           = new_run;
        last_atrial          = a_code;
        last_ventricular     = v_code;
        expected_results.push_back(res);
    endfunction

    // Compare one result with the oldest queued prediction.
    function void check_result(result_t got);
        result_t exp;

        if (expected_results.size() == 0) begin
            $error("result arrived with no tick request outstanding");
            errors++;
            return;
        end
        exp = expected_results.pop_front();
        if (got.atrial_code !== exp.atrial_code) begin
            $error("atrial_pace_code_out: expected %0d, actual %0d",
                   exp.atrial_code, got.atrial_code);
            errors++;
        end
        if (got.ventricular_code !== exp.ventricular_code) begin
            $error("ventricular_pace_code_out: expected %0d, actual %0d",
                   exp.ventricular_code, got.ventricular_code);
            errors++;
        end
        if (got.phases !== exp.phases) begin
            $error("timer_phases: expected %b, actual %b", exp.phases, got.phases);
            errors++;
        end
    endfunction
endclass

module tb_dual_chamber_pacing_timer_unit;

    localparam int unsigned WATCHDOG_LIMIT = 5000;
    localparam int unsigned PHASE_COUNT    = 8;
    localparam int unsigned PHASE_TICKS    = 60;
    localparam int unsigned DEFAULT_TICKS  = 300;
    localparam int unsigned HOLD_TICKS     = 60;

    // Code 3 is outside the defined pace codes.
    localparam code_t CODE_UNDEFINED = 2'd3;

    // Indexes with no register behind them.
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 3'd7;

    logic                 aclk                   = 1'b0;
    logic                 aresetn                = 1'b0;
    logic                 cfg_wr_en              = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_wr_index           = '0;
    logic [CNT_W-1:0]     cfg_wr_data            = '0;
    logic                 s_valid                = 1'b0;
    logic                 s_ready;
    logic                 s_atrial_sense         = 1'b0;
    logic                 s_ventricular_sense    = 1'b0;
    logic [CODE_W-1:0]    s_atrial_pace_code     = '0;
    logic [CODE_W-1:0]    s_ventricular_pace_code = '0;
    logic                 m_valid;
    logic                 m_ready                = 1'b0;
    logic [CODE_W-1:0]    m_atrial_pace_code_out;
    logic [CODE_W-1:0]    m_ventricular_pace_code_out;
    logic [NUM_TIMERS-1:0] m_timer_phases;

    pacing_scoreboard sb;
    bit               no_idle = 1'b0;

    dual_chamber_pacing_timer_unit DUT (
        .aclk                        (aclk),
        .aresetn                     (aresetn),
        .cfg_wr_en                   (cfg_wr_en),
        .cfg_wr_index                (cfg_wr_index),
        .cfg_wr_data                 (cfg_wr_data),
        .s_valid                     (s_valid),
        .s_ready                     (s_ready),
        .s_atrial_sense              (s_atrial_sense),
        .s_ventricular_sense         (s_ventricular_sense),
        .s_atrial_pace_code          (s_atrial_pace_code),
        .s_ventricular_pace_code     (s_ventricular_pace_code),
        .m_valid                     (m_valid),
        .m_ready                     (m_ready),
        .m_atrial_pace_code_out      (m_atrial_pace_code_out),
        .m_ventricular_pace_code_out (m_ventricular_pace_code_out),
        .m_timer_phases              (m_timer_phases)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Mostly back-to-back, sometimes a short gap, rarely a long pause.
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic tick_t make_tick(logic a_sense, logic v_sense, code_t a_code,
                                        code_t v_code);
        tick_t t;
        t.atrial_sense      = a_sense;
        t.ventricular_sense = v_sense;
        t.atrial_code       = a_code;
        t.ventricular_code  = v_code;
        return t;
    endfunction

    // A pending pace request is usually answered by a delivery on the next tick.
    function automatic code_t pick_code(code_t last, int unsigned noise_pm);
        int unsigned r;
        r = $urandom_range(0, 999);
        if (last == CODE_REQUESTED) begin
            if (r < 700) return CODE_DELIVERED;
            if (r < 900) return CODE_REQUESTED;
            return code_t'($urandom_range(0, 3));
        end
        if (r < noise_pm) return code_t'($urandom_range(0, 3));
        return CODE_IDLE;
    endfunction

    function automatic tick_t next_random_tick(int unsigned sense_pm, int unsigned noise_pm);
        if ($urandom_range(0, 999) < noise_pm)
            return make_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                             code_t'($urandom_range(0, 3)), code_t'($urandom_range(0, 3)));
        return make_tick($urandom_range(0, 999) < sense_pm,
                         $urandom_range(0, 999) < sense_pm,
                         pick_code(sb.last_atrial, noise_pm),
                         pick_code(sb.last_ventricular, noise_pm));
    endfunction

    function automatic count_t pick_limit();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 65) return count_t'($urandom_range(0, 12));
        if (r < 85) return count_t'($urandom_range(13, 60));
        if (r < 95) return count_t'($urandom_range(0, 1));
        return CNT_MAX;
    endfunction

    // Present one request after a random gap; returns at the next falling edge
    // after acceptance with valid still high.
    task automatic run_tick(input tick_t t);
        int unsigned gap;
        gap = pick_gap();
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid                 <= 1'b1;
        s_atrial_sense          <= t.atrial_sense;
        s_ventricular_sense     <= t.ventricular_sense;
        s_atrial_pace_code      <= t.atrial_code;
        s_ventricular_pace_code <= t.ventricular_code;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
    endtask

    // Stop sending and wait until every queued result has come back.
    task automatic drain();
        s_valid <= 1'b0;
        do @(negedge aclk); while (sb.pending() != 0);
    endtask

    task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input count_t value);
        cfg_wr_en    <= 1'b1;
        cfg_wr_index <= idx;
        cfg_wr_data  <= value;
        sb.write_limit(idx, value);
        @(negedge aclk);
    endtask

    // Write all six limits, then a stray write that must be ignored.
    task automatic program_limits(input limits_t l);
        write_cfg(REG_AV_DELAY, l.av_delay);
        write_cfg(REG_PVARP, l.pvarp);
        write_cfg(REG_VRP, l.vrp);
        write_cfg(REG_ATRIAL_ESC, l.atrial_escape);
        write_cfg(REG_LOWER_RATE, l.lower_rate);
        write_cfg(REG_UPPER_RATE, l.upper_rate);
        write_cfg($urandom_range(0, 1) ? REG_SPARE_A : REG_SPARE_B,
                  count_t'($urandom_range(0, 65535)));
        cfg_wr_en <= 1'b0;
        @(negedge aclk);
    endtask

    // Note accepted requests and check accepted results on each rising edge.
    always @(posedge aclk) begin : monitor
        tick_t   t;
        result_t r;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                r.atrial_code      = m_atrial_pace_code_out;
                r.ventricular_code = m_ventricular_pace_code_out;
                r.phases           = m_timer_phases;
                sb.check_result(r);
            end
            if (s_valid && s_ready) begin
                t = make_tick(s_atrial_sense, s_ventricular_sense,
                              s_atrial_pace_code, s_ventricular_pace_code);
                sb.note_tick(t);
            end
        end
    end

    // Result back-pressure: random stalls between runs of ready.
    initial begin : result_sink
        int unsigned hold;
        wait (aresetn === 1'b1);
        forever begin
            hold = pick_gap();
            if (hold != 0) begin
                m_ready <= 1'b0;
                repeat (hold) @(negedge aclk);
            end
            m_ready <= 1'b1;
            repeat ($urandom_range(1, 24)) @(negedge aclk);
        end
    end

    // End the run if neither channel moves for too long.
    initial begin : watchdog
        int unsigned quiet;
        quiet = 0;
        wait (aresetn === 1'b1);
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready)) quiet = 0;
            else quiet++;
        end
        $display("Verification failed");
        $finish;
    end

    initial begin : stimulus
        limits_t     l;
        int unsigned phase;
        int unsigned n;

        sb = new();
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed ticks at the reset limits: each event kind and code.
        run_tick(make_tick(1'b0, 1'b0, CODE_IDLE, CODE_IDLE));
        run_tick(make_tick(1'b1, 1'b0, CODE_IDLE, CODE_IDLE));
        run_tick(make_tick(1'b0, 1'b1, CODE_IDLE, CODE_IDLE));
        run_tick(make_tick(1'b1, 1'b0, CODE_DELIVERED, CODE_IDLE));
        run_tick(make_tick(1'b0, 1'b1, CODE_IDLE, CODE_DELIVERED));
        run_tick(make_tick(1'b0, 1'b0, CODE_UNDEFINED, CODE_UNDEFINED));
        run_tick(make_tick(1'b0, 1'b0, CODE_REQUESTED, CODE_REQUESTED));
        run_tick(make_tick(1'b0, 1'b0, CODE_DELIVERED, CODE_IDLE));
        run_tick(make_tick(1'b0, 1'b0, CODE_IDLE, CODE_DELIVERED));
        run_tick(make_tick(1'b1, 1'b1, CODE_UNDEFINED, CODE_UNDEFINED));
        run_tick(make_tick(1'b1, 1'b1, CODE_DELIVERED, CODE_DELIVERED));
        run_tick(make_tick(1'b0, 1'b1, CODE_REQUESTED, CODE_UNDEFINED));
        run_tick(make_tick(1'b1, 1'b0, CODE_UNDEFINED, CODE_REQUESTED));

        // Sparse activity so the shorter reset limits have time to expire.
        for (n = 0; n < DEFAULT_TICKS; n++) run_tick(next_random_tick(2, 5));

        // Random runs, each under its own set of limits.
        for (phase = 0; phase < PHASE_COUNT; phase++) begin
            drain();
            case (phase)
                0: l = '0;
                1: l = {6{CNT_MAX}};
                default: begin
                    l.av_delay      = pick_limit();
                    l.pvarp         = pick_limit();
                    l.vrp           = pick_limit();
                    l.atrial_escape = pick_limit();
                    l.lower_rate    = pick_limit();
                    l.upper_rate    = pick_limit();
                end
            endcase
            program_limits(l);
            for (n = 0; n < PHASE_TICKS; n++) begin
                // Hold off once mid-run until the pipeline is empty.
                if (phase == 4 && n == PHASE_TICKS / 2) drain();
                run_tick(next_random_tick(80, 100));
            end
        end

        // Bring the timers to rest with zero limits.
        drain();
        program_limits('0);
        repeat (4) run_tick(make_tick(1'b0, 1'b0, CODE_IDLE, CODE_IDLE));

        // Long limits: the AV delay keeps counting while the upper rate timer
        // runs, with requests sent back to back.
        drain();
        l               = {6{CNT_MAX}};
        l.pvarp         = '0;
        l.vrp           = '0;
        program_limits(l);
        no_idle = 1'b1;
        run_tick(make_tick(1'b1, 1'b0, CODE_IDLE, CODE_IDLE));
        run_tick(make_tick(1'b0, 1'b0, CODE_IDLE, CODE_DELIVERED));
        for (n = 0; n < HOLD_TICKS; n++)
            run_tick(make_tick(1'b0, 1'b0, CODE_IDLE, CODE_IDLE));
        no_idle = 1'b0;

        drain();
        repeat (8) @(posedge aclk);
        if (sb.pending() != 0) begin
            $error("%0d expected results never arrived", sb.pending());
            sb.errors++;
        end
        if (sb.errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
